// ===== rtl/core/rbnh_pkg.sv =====
// ----------------------------------------------------------------------------
// rbnh_pkg
// Types and constants shared by the ray and box query engine.
// ----------------------------------------------------------------------------
package rbnh_pkg;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_RAY   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Divider numerator width, quotient magnitude width and ray parameter width.
    localparam int DNW = 51;
    localparam int DQW = 50;
    localparam int TW  = 52;

    localparam logic signed [TW-1:0] T_NEG_INF = 52'shC000000000000;
    localparam logic signed [TW-1:0] T_POS_INF = 52'sh4000000000000;

    typedef enum logic [1:0] {
        K_NOP   = 2'd0,
        K_LOAD  = 2'd1,
        K_RAY   = 2'd2,
        K_CLEAR = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [5:0]         entry;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic [30:0]        limit;
        logic               ground;
        logic               enemy;
    } item_t;

endpackage

// ===== rtl/core/rbnh_front.sv =====
// ----------------------------------------------------------------------------
// rbnh_front
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module rbnh_front #(
    parameter int MAX_BOXES = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_func,
    input  logic [5:0]           s_entry_index,
    input  logic signed [31:0]   s_ax,
    input  logic signed [31:0]   s_ay,
    input  logic signed [31:0]   s_az,
    input  logic signed [31:0]   s_bx,
    input  logic signed [31:0]   s_by,
    input  logic signed [31:0]   s_bz,
    input  logic [30:0]          s_limit,
    input  logic                 s_ground_flag,
    input  logic                 s_enemy_flag,
    output logic                 q_valid,
    input  logic                 q_ready,
    output rbnh_pkg::item_t      q_item
);
    import rbnh_pkg::*;

    item_t      slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    item_t      in_item;
    logic       push;
    logic       pop;

    always_comb begin
        in_item.entry  = s_entry_index;
        in_item.ax     = s_ax;
        in_item.ay     = s_ay;
        in_item.az     = s_az;
        in_item.bx     = s_bx;
        in_item.by     = s_by;
        in_item.bz     = s_bz;
        in_item.limit  = s_limit;
        in_item.ground = s_ground_flag;
        in_item.enemy  = s_enemy_flag;
        priority if (s_func == FUNC_LOAD) begin
            in_item.kind = (int'({26'd0, s_entry_index}) < MAX_BOXES) ? K_LOAD : K_NOP;
        end else if (s_func == FUNC_RAY) begin
            in_item.kind = K_RAY;
        end else if (s_func == FUNC_CLEAR) begin
            in_item.kind = K_CLEAR;
        end else begin
            in_item.kind = K_NOP;
        end
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/rbnh_div.sv =====
// ----------------------------------------------------------------------------
// rbnh_div
// Signed divider, truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbnh_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [rbnh_pkg::DNW-1:0]   num,
    input  logic signed [31:0]                den,
    output logic                              done,
    output logic signed [rbnh_pkg::TW-1:0]    quo
);
    import rbnh_pkg::*;

    localparam int CW = $clog2(DQW + 1);

    logic           busy_reg;
    logic           done_reg;
    logic           neg_reg;
    logic [DQW-1:0] num_reg;
    logic [31:0]    rem_reg;
    logic [31:0]    den_reg;
    logic [CW-1:0]  cnt_reg;
    logic [DNW-1:0] num_abs;
    logic [31:0]    den_abs;
    logic [32:0]    shifted;
    logic [32:0]    diff;
    logic           ge;

    assign num_abs = num[DNW-1] ? (~num + 1'b1) : num;
    assign den_abs = den[31] ? (~den + 1'b1) : den;
    assign shifted = {rem_reg, num_reg[DQW-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});
    assign done    = done_reg;
    assign quo     = neg_reg ? -$signed({2'b00, num_reg}) : $signed({2'b00, num_reg});

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            num_reg <= num_abs[DQW-1:0];
            den_reg <= den_abs;
            rem_reg <= 32'd0;
            neg_reg <= num[DNW-1] ^ den[31];
        end else if (busy_reg) begin
            num_reg <= {num_reg[DQW-2:0], ge};
            rem_reg <= ge ? diff[31:0] : shifted[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DQW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/rbnh_back.sv =====
// ----------------------------------------------------------------------------
// rbnh_back
// Box table, ray slab walk, floor test, clearance walk and result register.
// ----------------------------------------------------------------------------
module rbnh_back #(
    parameter int MAX_BOXES = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  rbnh_pkg::item_t      q_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_hit,
    output logic [30:0]          m_distance,
    output logic signed [31:0]   m_point_x,
    output logic signed [31:0]   m_point_y,
    output logic signed [31:0]   m_point_z,
    output logic signed [1:0]    m_normal_x,
    output logic signed [1:0]    m_normal_y,
    output logic signed [1:0]    m_normal_z,
    output logic signed [6:0]    m_hit_entry,
    output logic                 m_clear
);
    import rbnh_pkg::*;

    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic signed [1:0]  NRM_NEG = 2'sb11;
    localparam logic signed [1:0]  NRM_POS = 2'sb01;
    localparam logic signed [63:0] SAT_MAX = 64'sh000000007FFFFFFF;
    localparam logic signed [63:0] SAT_MIN = 64'shFFFFFFFF80000000;

    typedef enum logic [14:0] {
        ST_IDLE  = 15'h0001,
        ST_RD    = 15'h0002,
        ST_CHK   = 15'h0004,
        ST_AXIS  = 15'h0008,
        ST_DIV0  = 15'h0010,
        ST_DIV1  = 15'h0020,
        ST_BOX   = 15'h0040,
        ST_FLOOR = 15'h0080,
        ST_FDIV  = 15'h0100,
        ST_PMUL  = 15'h0200,
        ST_PADD  = 15'h0400,
        ST_CAX   = 15'h0800,
        ST_CSQ   = 15'h1000,
        ST_CEND  = 15'h2000,
        ST_OUT   = 15'h4000
    } state_t;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
        logic               ground;
        logic               enemy;
    } box_t;

    function automatic logic signed [31:0] pick3(input logic [1:0] ax,
                                                 input logic signed [31:0] x,
                                                 input logic signed [31:0] y,
                                                 input logic signed [31:0] z);
        logic signed [31:0] r;
        unique case (ax)
            AX_X:    r = x;
            AX_Y:    r = y;
            AX_Z:    r = z;
            default: r = z;
        endcase
        return r;
    endfunction

    state_t                  state_reg;
    item_t                   item_reg;
    box_t                    mem [MAX_BOXES];
    box_t                    rdata_reg;
    logic [MAX_BOXES-1:0]    valid_bits_reg;
    logic [AW-1:0]           idx_reg;
    logic [1:0]              axis_reg;
    logic signed [TW-1:0]    near_reg;
    logic signed [TW-1:0]    far_reg;
    logic signed [TW-1:0]    t0_reg;
    logic signed [TW-1:0]    best_reg;
    logic signed [TW-1:0]    tmin_reg [3];
    logic                    hit_reg;
    logic                    floor_reg;
    logic [6:0]              entry_reg;
    logic [1:0]              naxis_reg;
    logic signed [1:0]       nsign_reg;
    logic                    clear_reg;
    logic [61:0]             r2_reg;
    logic [61:0]             sq_reg;
    logic [63:0]             sum_reg;
    logic signed [63:0]      prod_reg;
    logic signed [31:0]      px_reg;
    logic signed [31:0]      py_reg;
    logic signed [31:0]      pz_reg;

    logic                    m_valid_reg;
    logic                    m_hit_reg;
    logic [30:0]             m_distance_reg;
    logic signed [31:0]      m_point_x_reg;
    logic signed [31:0]      m_point_y_reg;
    logic signed [31:0]      m_point_z_reg;
    logic signed [1:0]       m_normal_x_reg;
    logic signed [1:0]       m_normal_y_reg;
    logic signed [1:0]       m_normal_z_reg;
    logic signed [6:0]       m_hit_entry_reg;
    logic                    m_clear_reg;

    logic                    is_ray;
    logic                    adv_last;
    state_t                  adv_state;
    logic signed [31:0]      o_ax;
    logic signed [31:0]      d_ax;
    logic signed [31:0]      c_ax;
    logic signed [31:0]      s_ax;
    logic signed [33:0]      o_w;
    logic signed [33:0]      c_w;
    logic signed [33:0]      h_w;
    logic signed [33:0]      lo;
    logic signed [33:0]      hi;
    logic signed [33:0]      dlo;
    logic signed [33:0]      dhi;
    logic signed [33:0]      noy;
    logic signed [33:0]      clamp;
    logic signed [33:0]      df;
    logic [33:0]             adf;
    logic                    far_ax;
    logic signed [TW-1:0]    tmn;
    logic signed [TW-1:0]    tmx;
    logic [1:0]              first_ax;
    logic signed [31:0]      d_first;
    logic                    box_hit;
    logic signed [63:0]      pt_sum;
    logic signed [31:0]      pt_sat;
    logic                    out_free;

    logic                    div_start;
    logic signed [DNW-1:0]   div_num;
    logic                    div_done;
    logic signed [TW-1:0]    div_quo;

    rbnh_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     ((state_reg == ST_FLOOR) ? item_reg.by : d_ax),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign q_ready  = (state_reg == ST_IDLE);
    assign is_ray   = (item_reg.kind == K_RAY);
    assign adv_last = (idx_reg == AW'(MAX_BOXES - 1));
    assign adv_state = adv_last ? (is_ray ? ST_FLOOR : ST_OUT) : ST_RD;
    assign out_free = !m_valid_reg || m_ready;

    assign o_ax = pick3(axis_reg, item_reg.ax, item_reg.ay, item_reg.az);
    assign d_ax = pick3(axis_reg, item_reg.bx, item_reg.by, item_reg.bz);
    assign c_ax = pick3(axis_reg, rdata_reg.cx, rdata_reg.cy, rdata_reg.cz);
    assign s_ax = pick3(axis_reg, rdata_reg.sx, rdata_reg.sy, rdata_reg.sz);

    assign o_w  = {{2{o_ax[31]}}, o_ax};
    assign c_w  = {{2{c_ax[31]}}, c_ax};
    assign h_w  = {{3{s_ax[31]}}, s_ax[31:1]};
    assign lo   = c_w - h_w;
    assign hi   = c_w + h_w;
    assign dlo  = lo - o_w;
    assign dhi  = hi - o_w;
    assign noy  = 34'sd0 - {{2{item_reg.ay[31]}}, item_reg.ay};

    assign clamp  = (o_w > lo) ? ((o_w > hi) ? hi : o_w) : ((lo > hi) ? hi : lo);
    assign df     = o_w - clamp;
    assign adf    = df[33] ? (~df + 1'b1) : df;
    assign far_ax = (adf[33:31] != 3'd0);

    assign tmn = (t0_reg < div_quo) ? t0_reg : div_quo;
    assign tmx = (t0_reg < div_quo) ? div_quo : t0_reg;

    assign first_ax = (near_reg == tmin_reg[0]) ? AX_X :
                      (near_reg == tmin_reg[1]) ? AX_Y : AX_Z;
    assign d_first  = pick3(first_ax, item_reg.bx, item_reg.by, item_reg.bz);
    assign box_hit  = (near_reg <= far_reg) && (far_reg >= 0) &&
                      (near_reg < best_reg) && (near_reg > 0);

    assign pt_sum = (prod_reg >>> 16) + 64'(o_ax);
    assign pt_sat = (pt_sum > SAT_MAX) ? 32'sh7FFFFFFF :
                    (pt_sum < SAT_MIN) ? 32'sh80000000 : pt_sum[31:0];

    always_comb begin
        div_start = 1'b0;
        div_num   = {dlo[33], dlo, 16'd0};
        unique case (state_reg)
            ST_AXIS: begin
                div_start = (d_ax != 32'sd0);
            end
            ST_DIV0: begin
                div_start = div_done;
                div_num   = {dhi[33], dhi, 16'd0};
            end
            ST_FLOOR: begin
                div_start = (item_reg.by != 32'sd0);
                div_num   = {noy[33], noy, 16'd0};
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid && q_item.kind == K_LOAD) begin
            mem[AW'(q_item.entry)] <= '{q_item.ax, q_item.ay, q_item.az,
                                        q_item.bx, q_item.by, q_item.bz,
                                        q_item.ground, q_item.enemy};
        end
        rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    item_reg  <= q_item;
                    hit_reg   <= 1'b0;
                    floor_reg <= 1'b0;
                    entry_reg <= 7'd0;
                    naxis_reg <= AX_X;
                    nsign_reg <= 2'sd0;
                    best_reg  <= $signed({{(TW-31){1'b0}}, q_item.limit});
                    clear_reg <= (q_item.kind == K_CLEAR);
                    r2_reg    <= q_item.limit * q_item.limit;
                    px_reg    <= 32'sd0;
                    py_reg    <= 32'sd0;
                    pz_reg    <= 32'sd0;
                    idx_reg   <= '0;
                    axis_reg  <= AX_X;
                end
            end
            ST_RD: begin
                if (!valid_bits_reg[idx_reg] && !adv_last) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_CHK: begin
                if ((rdata_reg.ground || (!is_ray && rdata_reg.enemy)) && !adv_last) begin
                    idx_reg <= idx_reg + 1'b1;
                end
                axis_reg <= AX_X;
                near_reg <= T_NEG_INF;
                far_reg  <= T_POS_INF;
                sum_reg  <= 64'd0;
            end
            ST_AXIS: begin
                if (d_ax == 32'sd0) begin
                    if (o_w < lo || o_w > hi) begin
                        if (!adv_last) begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end else begin
                        tmin_reg[axis_reg] <= T_NEG_INF;
                        if (axis_reg != AX_Z) begin
                            axis_reg <= axis_reg + 2'd1;
                        end
                    end
                end
            end
            ST_DIV0: begin
                if (div_done) begin
                    t0_reg <= div_quo;
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    tmin_reg[axis_reg] <= tmn;
                    if (tmn > near_reg) begin
                        near_reg <= tmn;
                    end
                    if (tmx < far_reg) begin
                        far_reg <= tmx;
                    end
                    if (axis_reg != AX_Z) begin
                        axis_reg <= axis_reg + 2'd1;
                    end
                end
            end
            ST_BOX: begin
                if (box_hit) begin
                    hit_reg   <= 1'b1;
                    best_reg  <= near_reg;
                    entry_reg <= 7'(idx_reg);
                    naxis_reg <= first_ax;
                    nsign_reg <= (d_first > 0) ? NRM_NEG : NRM_POS;
                end
                if (!adv_last) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_FLOOR: begin
                axis_reg <= AX_X;
            end
            ST_FDIV: begin
                if (div_done && div_quo > 0 && div_quo < best_reg) begin
                    hit_reg   <= 1'b1;
                    best_reg  <= div_quo;
                    floor_reg <= 1'b1;
                    naxis_reg <= AX_Y;
                    nsign_reg <= NRM_POS;
                end
                axis_reg <= AX_X;
            end
            ST_PMUL: begin
                prod_reg <= d_ax * $signed({1'b0, best_reg[30:0]});
            end
            ST_PADD: begin
                unique case (axis_reg)
                    AX_X:    px_reg <= pt_sat;
                    AX_Y:    py_reg <= pt_sat;
                    default: pz_reg <= pt_sat;
                endcase
                if (axis_reg != AX_Z) begin
                    axis_reg <= axis_reg + 2'd1;
                end
            end
            ST_CAX: begin
                sq_reg <= adf[30:0] * adf[30:0];
                if (far_ax && !adv_last) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_CSQ: begin
                sum_reg <= sum_reg + 64'(sq_reg);
                if (axis_reg != AX_Z) begin
                    axis_reg <= axis_reg + 2'd1;
                end
            end
            ST_CEND: begin
                if (sum_reg < 64'(r2_reg)) begin
                    clear_reg <= 1'b0;
                end else if (!adv_last) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_hit_reg       <= hit_reg;
                    m_distance_reg  <= hit_reg ? best_reg[30:0] : 31'd0;
                    m_point_x_reg   <= px_reg;
                    m_point_y_reg   <= py_reg;
                    m_point_z_reg   <= pz_reg;
                    m_normal_x_reg  <= (hit_reg && naxis_reg == AX_X) ? nsign_reg : 2'sd0;
                    m_normal_y_reg  <= (hit_reg && naxis_reg == AX_Y) ? nsign_reg : 2'sd0;
                    m_normal_z_reg  <= (hit_reg && naxis_reg == AX_Z) ? nsign_reg : 2'sd0;
                    m_hit_entry_reg <= !hit_reg ? 7'sd0 :
                                       (floor_reg ? -7'sd1 : $signed(entry_reg));
                    m_clear_reg     <= clear_reg;
                end
            end
            default: begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_bits_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        if (q_item.kind == K_LOAD) begin
                            valid_bits_reg[AW'(q_item.entry)] <= 1'b1;
                            state_reg <= ST_OUT;
                        end else if (q_item.kind == K_NOP) begin
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_RD: begin
                    state_reg <= valid_bits_reg[idx_reg] ? ST_CHK : adv_state;
                end
                ST_CHK: begin
                    if (rdata_reg.ground || (!is_ray && rdata_reg.enemy)) begin
                        state_reg <= adv_state;
                    end else begin
                        state_reg <= is_ray ? ST_AXIS : ST_CAX;
                    end
                end
                ST_AXIS: begin
                    if (d_ax != 32'sd0) begin
                        state_reg <= ST_DIV0;
                    end else if (o_w < lo || o_w > hi) begin
                        state_reg <= adv_state;
                    end else if (axis_reg == AX_Z) begin
                        state_reg <= ST_BOX;
                    end
                end
                ST_DIV0: begin
                    if (div_done) begin
                        state_reg <= ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    if (div_done) begin
                        state_reg <= (axis_reg == AX_Z) ? ST_BOX : ST_AXIS;
                    end
                end
                ST_BOX: begin
                    state_reg <= adv_state;
                end
                ST_FLOOR: begin
                    state_reg <= (item_reg.by != 32'sd0) ? ST_FDIV : ST_PMUL;
                end
                ST_FDIV: begin
                    if (div_done) begin
                        state_reg <= ST_PMUL;
                    end
                end
                ST_PMUL: begin
                    state_reg <= hit_reg ? ST_PADD : ST_OUT;
                end
                ST_PADD: begin
                    state_reg <= (axis_reg == AX_Z) ? ST_OUT : ST_PMUL;
                end
                ST_CAX: begin
                    state_reg <= far_ax ? adv_state : ST_CSQ;
                end
                ST_CSQ: begin
                    state_reg <= (axis_reg == AX_Z) ? ST_CEND : ST_CAX;
                end
                ST_CEND: begin
                    state_reg <= (sum_reg < 64'(r2_reg)) ? ST_OUT : adv_state;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_hit       = m_hit_reg;
    assign m_distance  = m_distance_reg;
    assign m_point_x   = m_point_x_reg;
    assign m_point_y   = m_point_y_reg;
    assign m_point_z   = m_point_z_reg;
    assign m_normal_x  = m_normal_x_reg;
    assign m_normal_y  = m_normal_y_reg;
    assign m_normal_z  = m_normal_z_reg;
    assign m_hit_entry = m_hit_entry_reg;
    assign m_clear     = m_clear_reg;

endmodule

// ===== rtl/core/ray_box_nearest_hit.sv =====
// ----------------------------------------------------------------------------
// ray_box_nearest_hit
// Box table with a nearest-hit ray caster and a sphere clearance test.
// ----------------------------------------------------------------------------
// The input channel takes one beat per item: a load writes one box entry, a
// ray beat casts a ray against all valid non-ground boxes and the floor plane,
// and a clearance beat tests a sphere against all obstacle boxes. Every beat
// yields exactly one result beat on the m_ channel, in input order.
// A two-entry queue sits between the input side and the query engine, so up
// to two further beats are taken while a query runs.
// A ray query walks every table entry one at a time. Each non-parallel axis of
// a tested box needs two divisions on one shared divider that yields one
// quotient bit a cycle. The floor test and hit point follow the walk.
// A clearance query squares the axis distances of each obstacle box on the one
// shared squaring multiplier and stops at the first overlap.
// Reset empties the table and the queue and drops any pending result.
// When the receiver stalls, the result stays in the output register and the
// engine waits after finishing its next item; the queue then fills.
// ----------------------------------------------------------------------------
module ray_box_nearest_hit #(
    parameter int MAX_BOXES = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_func,
    input  logic [5:0]           s_entry_index,
    input  logic signed [31:0]   s_ax,
    input  logic signed [31:0]   s_ay,
    input  logic signed [31:0]   s_az,
    input  logic signed [31:0]   s_bx,
    input  logic signed [31:0]   s_by,
    input  logic signed [31:0]   s_bz,
    input  logic [30:0]          s_limit,
    input  logic                 s_ground_flag,
    input  logic                 s_enemy_flag,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_hit,
    output logic [30:0]          m_distance,
    output logic signed [31:0]   m_point_x,
    output logic signed [31:0]   m_point_y,
    output logic signed [31:0]   m_point_z,
    output logic signed [1:0]    m_normal_x,
    output logic signed [1:0]    m_normal_y,
    output logic signed [1:0]    m_normal_z,
    output logic signed [6:0]    m_hit_entry,
    output logic                 m_clear
);
    import rbnh_pkg::*;

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    rbnh_front #(
        .MAX_BOXES (MAX_BOXES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_entry_index (s_entry_index),
        .s_ax          (s_ax),
        .s_ay          (s_ay),
        .s_az          (s_az),
        .s_bx          (s_bx),
        .s_by          (s_by),
        .s_bz          (s_bz),
        .s_limit       (s_limit),
        .s_ground_flag (s_ground_flag),
        .s_enemy_flag  (s_enemy_flag),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    rbnh_back #(
        .MAX_BOXES (MAX_BOXES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_distance  (m_distance),
        .m_point_x   (m_point_x),
        .m_point_y   (m_point_y),
        .m_point_z   (m_point_z),
        .m_normal_x  (m_normal_x),
        .m_normal_y  (m_normal_y),
        .m_normal_z  (m_normal_z),
        .m_hit_entry (m_hit_entry),
        .m_clear     (m_clear)
    );

endmodule

// ===== rtl/core/rbnh_checker.sv =====
// ----------------------------------------------------------------------------
// rbnh_checker
// Port-level checks on result beats, bound to the top level.
// ----------------------------------------------------------------------------
module rbnh_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_hit,
    input logic [30:0]         m_distance,
    input logic signed [1:0]   m_normal_y,
    input logic signed [6:0]   m_hit_entry,
    input logic                m_clear
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance) && $stable(m_hit_entry))
        else $error("Result beat changed while stalled.");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result beat valid right after reset.");

    a_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit && m_hit_entry == -7'sd1 |-> m_normal_y == 2'sd1)
        else $error("Floor hit without an upward normal.");

    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_distance == 31'd0 && m_hit_entry == 7'sd0)
        else $error("Miss carries a distance or an entry.");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clear |-> !m_hit)
        else $error("Result beat is both a hit and a clearance.");

endmodule

bind ray_box_nearest_hit rbnh_checker u_rbnh_checker (.*);
